/* rtl/core/sfcs_pkg.sv */
// shared types and codes for the spi flash command sequencer
// no dependencies; imported by every module of the block
package sfcs_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int DEVICE_BYTES_DEF = 1048576;
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = $clog2(QDEPTH);

  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_ERASE  = 3'd2;
  localparam logic [2:0] MODE_STATUS = 3'd3;
  localparam logic [2:0] MODE_RBYTE  = 3'd4;
  localparam logic [2:0] MODE_WBYTE  = 3'd5;

  localparam logic [2:0] K_SPI   = 3'd0;
  localparam logic [2:0] K_HOST  = 3'd1;
  localparam logic [2:0] K_DONE  = 3'd2;
  localparam logic [2:0] K_ALIGN = 3'd3;
  localparam logic [2:0] K_PHASE = 3'd4;

  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_SE   = 8'hd8;

  // result sequences that one request turns into
  localparam logic [3:0] SEQ_ALIGN      = 4'd0;
  localparam logic [3:0] SEQ_PHASE      = 4'd1;
  localparam logic [3:0] SEQ_DONE       = 4'd2;
  localparam logic [3:0] SEQ_RDSR       = 4'd3;
  localparam logic [3:0] SEQ_PROG       = 4'd4;
  localparam logic [3:0] SEQ_ERASE_DONE = 4'd5;
  localparam logic [3:0] SEQ_ERASE_POLL = 4'd6;
  localparam logic [3:0] SEQ_READ       = 4'd7;
  localparam logic [3:0] SEQ_READ_DONE  = 4'd8;
  localparam logic [3:0] SEQ_HOST       = 4'd9;
  localparam logic [3:0] SEQ_HOST_DONE  = 4'd10;
  localparam logic [3:0] SEQ_WDATA      = 4'd11;
  localparam logic [3:0] SEQ_WDATA_DONE = 4'd12;
  localparam logic [3:0] SEQ_WDATA_POLL = 4'd13;

  typedef struct packed {
    logic [3:0]  seq;
    logic [23:0] addr;
    logic [20:0] ra;
    logic [7:0]  dbyte;
    logic        fe;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } qwr_t;

endpackage

/* rtl/core/spi_flash_command_sequencer.sv */
// spi nor flash command sequencer: read, page program and sector erase to spi byte frames
// depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back
// One request is taken per cycle while the four-entry descriptor queue has room; the back
// end delivers one result per cycle while out_stall is low; a request gives one or two
// results for status, data bytes and errors, four to six when a poll clears and a command
// header goes out. All but an empty program or erase and a misaligned erase start with
// an RDSR poll repeated while write-in-progress is set; program and erase get a write-enable
// frame first, programs split at page boundaries and erases are checked against the erase
// unit. Page and device sizes are powers of two; addresses wrap at the device size.
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int DEVICE_BYTES = DEVICE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [23:0] in_address,
  input  logic [20:0] in_length,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_frame_start,
  output logic        out_frame_end,
  output logic [20:0] out_read_after,
  output logic        out_last
);

  qwr_t  qwr;
  desc_t head;
  logic  full, empty, pop;

  assign in_stall = full;

  sfcs_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .DEVICE_BYTES (DEVICE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (in_valid && !full),
    .mode      (in_mode),
    .address   (in_address),
    .length    (in_length),
    .data      (in_data),
    .qwr       (qwr)
  );

  sfcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  sfcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_read_after  (out_read_after),
    .out_last        (out_last)
  );

endmodule

/* rtl/core/sfcs_front.sv */
// front end: accepts requests, tracks the operation phase and emits job descriptors
// depends on sfcs_pkg
module sfcs_front import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int DEVICE_BYTES = DEVICE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        accept,
  input  logic [2:0]  mode,
  input  logic [23:0] address,
  input  logic [20:0] length,
  input  logic [7:0]  data,
  output qwr_t        qwr
);

  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam logic [23:0] DEV_MASK = 24'(DEVICE_BYTES - 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_POLL  = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;
  localparam logic [1:0] PH_WRITE = 2'd3;

  logic [4:0]        shift_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [23:0]       cur_r, cur_nxt;
  logic [20:0]       left_r, left_nxt;
  logic [PAGE_W:0]   page_r, page_nxt;

  logic [4:0]        sh;
  logic [20:0]       um;
  logic [20:0]       unit;
  logic [PAGE_W:0]   room;
  logic [PAGE_W:0]   page_dec;
  logic [20:0]       left_dec;
  desc_t             d;

  always_comb begin
    if (shift_r < 5'd8) begin
      sh = 5'd8;
    end else if (shift_r > 5'd20) begin
      sh = 5'd20;
    end else begin
      sh = shift_r;
    end
    unit = 21'd1 << sh;
    um   = unit - 21'd1;
    room = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, cur_r[PAGE_W-1:0]};
    page_dec = (page_r != '0) ? page_r - 1'b1 : page_r;
    left_dec = (left_r != '0) ? left_r - 21'd1 : left_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    page_nxt  = page_r;
    d.seq     = SEQ_PHASE;
    d.addr    = cur_r;
    d.ra      = '0;
    d.dbyte   = ~data;
    d.fe      = 1'b0;
    if (mode <= MODE_ERASE && phase_r == PH_IDLE) begin
      if (mode == MODE_ERASE && ((address & {3'b000, um}) != '0 || (length & um) != '0)) begin
        d.seq = SEQ_ALIGN;
      end else begin
        op_nxt   = mode[1:0];
        cur_nxt  = address & DEV_MASK;
        left_nxt = length;
        if (mode != MODE_READ && length == '0) begin
          d.seq = SEQ_DONE;
        end else begin
          d.seq     = SEQ_RDSR;
          phase_nxt = PH_POLL;
        end
      end
    end else if (mode == MODE_STATUS && phase_r == PH_POLL) begin
      if (data[0]) begin
        d.seq = SEQ_RDSR;
      end else if (op_r == MODE_WRITE[1:0]) begin
        d.seq     = SEQ_PROG;
        page_nxt  = (21'(room) < left_r) ? room : left_r[PAGE_W:0];
        phase_nxt = PH_WRITE;
      end else if (op_r == MODE_ERASE[1:0]) begin
        d.fe     = 1'b1;
        cur_nxt  = (cur_r + {3'b000, unit}) & DEV_MASK;
        left_nxt = (left_r > unit) ? left_r - unit : '0;
        if (left_r <= unit) begin
          d.seq     = SEQ_ERASE_DONE;
          phase_nxt = PH_IDLE;
        end else begin
          d.seq = SEQ_ERASE_POLL;
        end
      end else begin
        d.fe = 1'b1;
        d.ra = left_r;
        if (left_r == '0) begin
          d.seq     = SEQ_READ_DONE;
          phase_nxt = PH_IDLE;
        end else begin
          d.seq     = SEQ_READ;
          phase_nxt = PH_READ;
        end
      end
    end else if (mode == MODE_RBYTE && phase_r == PH_READ) begin
      left_nxt = left_dec;
      if (left_dec == '0) begin
        d.seq     = SEQ_HOST_DONE;
        phase_nxt = PH_IDLE;
      end else begin
        d.seq = SEQ_HOST;
      end
    end else if (mode == MODE_WBYTE && phase_r == PH_WRITE) begin
      page_nxt = page_dec;
      left_nxt = left_dec;
      cur_nxt  = (cur_r + 24'd1) & DEV_MASK;
      d.fe     = (page_dec == '0);
      if (page_dec != '0) begin
        d.seq = SEQ_WDATA;
      end else if (left_dec == '0) begin
        d.seq     = SEQ_WDATA_DONE;
        phase_nxt = PH_IDLE;
      end else begin
        d.seq     = SEQ_WDATA_POLL;
        phase_nxt = PH_POLL;
      end
    end
  end

  assign qwr.push = accept;
  assign qwr.desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 5'd16;
      phase_r <= PH_IDLE;
      op_r    <= '0;
      cur_r   <= '0;
      left_r  <= '0;
      page_r  <= '0;
    end else begin
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        op_r    <= op_nxt;
        cur_r   <= cur_nxt;
        left_r  <= left_nxt;
        page_r  <= page_nxt;
      end
    end
  end

endmodule

/* rtl/core/sfcs_queue.sv */
// short descriptor queue between front end and back end
// depends on sfcs_pkg
module sfcs_queue import sfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  qwr_t  qwr,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output desc_t head
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign do_push = qwr.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= qwr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/sfcs_back.sv */
// back end: expands job descriptors into spi bytes and host results
// depends on sfcs_pkg
module sfcs_back import sfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  desc_t       head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_frame_start,
  output logic        out_frame_end,
  output logic [20:0] out_read_after,
  output logic        out_last
);

  localparam logic [3:0] STP_ALIGN = 4'd0;
  localparam logic [3:0] STP_PHASE = 4'd1;
  localparam logic [3:0] STP_DONE  = 4'd2;
  localparam logic [3:0] STP_RDSR  = 4'd3;
  localparam logic [3:0] STP_WREN  = 4'd4;
  localparam logic [3:0] STP_PP    = 4'd5;
  localparam logic [3:0] STP_SE    = 4'd6;
  localparam logic [3:0] STP_RD    = 4'd7;
  localparam logic [3:0] STP_A2    = 4'd8;
  localparam logic [3:0] STP_A1    = 4'd9;
  localparam logic [3:0] STP_A0    = 4'd10;
  localparam logic [3:0] STP_HOST  = 4'd11;
  localparam logic [3:0] STP_WDATA = 4'd12;

  function automatic logic [2:0] seq_len(input logic [3:0] seq);
    case (seq)
      SEQ_PROG:       seq_len = 3'd5;
      SEQ_ERASE_DONE: seq_len = 3'd6;
      SEQ_ERASE_POLL: seq_len = 3'd6;
      SEQ_READ:       seq_len = 3'd4;
      SEQ_READ_DONE:  seq_len = 3'd5;
      SEQ_HOST_DONE:  seq_len = 3'd2;
      SEQ_WDATA_DONE: seq_len = 3'd2;
      SEQ_WDATA_POLL: seq_len = 3'd2;
      default:        seq_len = 3'd1;
    endcase
  endfunction

  function automatic logic [3:0] seq_step(input logic [3:0] seq, input logic [2:0] idx);
    logic [3:0] s;
    s = STP_PHASE;
    case (seq)
      SEQ_ALIGN: s = STP_ALIGN;
      SEQ_DONE:  s = STP_DONE;
      SEQ_RDSR:  s = STP_RDSR;
      SEQ_PROG, SEQ_ERASE_DONE, SEQ_ERASE_POLL: begin
        case (idx)
          3'd0:    s = STP_WREN;
          3'd1:    s = (seq == SEQ_PROG) ? STP_PP : STP_SE;
          3'd2:    s = STP_A2;
          3'd3:    s = STP_A1;
          3'd4:    s = STP_A0;
          default: s = (seq == SEQ_ERASE_DONE) ? STP_DONE : STP_RDSR;
        endcase
      end
      SEQ_READ, SEQ_READ_DONE: begin
        case (idx)
          3'd0:    s = STP_RD;
          3'd1:    s = STP_A2;
          3'd2:    s = STP_A1;
          3'd3:    s = STP_A0;
          default: s = STP_DONE;
        endcase
      end
      SEQ_HOST, SEQ_HOST_DONE: begin
        s = (idx == 3'd0) ? STP_HOST : STP_DONE;
      end
      SEQ_WDATA, SEQ_WDATA_DONE, SEQ_WDATA_POLL: begin
        if (idx == 3'd0) begin
          s = STP_WDATA;
        end else begin
          s = (seq == SEQ_WDATA_POLL) ? STP_RDSR : STP_DONE;
        end
      end
      default: s = STP_PHASE;
    endcase
    return s;
  endfunction

  logic [2:0]  idx_r;
  logic        vld_r;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        fs_r, fs_nxt;
  logic        fe_r, fe_nxt;
  logic [20:0] ra_r, ra_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic [3:0]  step;

  assign load = !empty && (!vld_r || !out_stall);
  assign pop  = load && last_nxt;
  assign step = seq_step(head.seq, idx_r);

  always_comb begin
    kind_nxt = K_SPI;
    byte_nxt = '0;
    fs_nxt   = 1'b0;
    fe_nxt   = 1'b0;
    ra_nxt   = '0;
    last_nxt = (idx_r == seq_len(head.seq) - 3'd1);
    case (step)
      STP_ALIGN: kind_nxt = K_ALIGN;
      STP_DONE:  kind_nxt = K_DONE;
      STP_RDSR: begin
        byte_nxt = CMD_RDSR;
        fs_nxt   = 1'b1;
        fe_nxt   = 1'b1;
        ra_nxt   = 21'd1;
      end
      STP_WREN: begin
        byte_nxt = CMD_WREN;
        fs_nxt   = 1'b1;
        fe_nxt   = 1'b1;
      end
      STP_PP: begin
        byte_nxt = CMD_PP;
        fs_nxt   = 1'b1;
      end
      STP_SE: begin
        byte_nxt = CMD_SE;
        fs_nxt   = 1'b1;
      end
      STP_RD: begin
        byte_nxt = CMD_READ;
        fs_nxt   = 1'b1;
      end
      STP_A2: byte_nxt = head.addr[23:16];
      STP_A1: byte_nxt = head.addr[15:8];
      STP_A0: begin
        byte_nxt = head.addr[7:0];
        fe_nxt   = head.fe;
        ra_nxt   = head.ra;
      end
      STP_HOST: begin
        kind_nxt = K_HOST;
        byte_nxt = head.dbyte;
      end
      STP_WDATA: begin
        byte_nxt = head.dbyte;
        fe_nxt   = head.fe;
      end
      default: kind_nxt = K_PHASE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= last_nxt ? 3'd0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      fs_r   <= fs_nxt;
      fe_r   <= fe_nxt;
      ra_r   <= ra_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = vld_r;
  assign out_kind        = kind_r;
  assign out_out_byte    = byte_r;
  assign out_frame_start = fs_r;
  assign out_frame_end   = fe_r;
  assign out_read_after  = ra_r;
  assign out_last        = last_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'd5)
    else $error("step index past longest sequence");

  a_flags_spi_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_SPI |-> !out_frame_start && !out_frame_end
      && out_read_after == '0)
    else $error("frame flags on a non spi result");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && out_last && idx_r == 3'd0)
    else $error("descriptor retired without last result");

endmodule

/* verif/sfcs_checker.sv */
`timescale 1ns / 1ps
// checker for the spi flash command sequencer: predicts the result frames of every
// accepted request and compares them field by field with what the block delivers
// depends on sfcs_pkg for codes, command bytes and page/device sizes
module sfcs_checker import sfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [23:0] in_address,
  input  logic [20:0] in_length,
  input  logic [7:0]  in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_out_byte,
  input  logic        out_frame_start,
  input  logic        out_frame_end,
  input  logic [20:0] out_read_after,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef enum logic [1:0] {ST_IDLE, ST_POLL, ST_READ, ST_WRITE} flash_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  obyte;
    logic        fs;
    logic        fe;
    logic [20:0] ra;
    logic        last;
  } frame_res_t;

  localparam int unsigned DEV  = DEVICE_BYTES_DEF;
  localparam int unsigned PAGE = PAGE_BYTES_DEF;

  frame_res_t   frame_q[$];
  frame_res_t   step_res[6];
  frame_res_t   want;
  int           step_n;
  flash_phase_t phase;
  logic [2:0]   op;
  logic [4:0]   erase_shift;
  int unsigned  cur_addr;
  int unsigned  left;
  int unsigned  page_rem;

  function automatic int unsigned sector_bytes(input logic [4:0] s);
    int unsigned v;
    v = s;
    if (v < 8) v = 8;
    if (v > 20) v = 20;
    return 32'd1 << v;
  endfunction

  task automatic add_res(input logic [2:0] k, input logic [7:0] b, input logic fs,
                         input logic fe, input logic [20:0] ra);
    step_res[step_n].kind  = k;
    step_res[step_n].obyte = b;
    step_res[step_n].fs    = fs;
    step_res[step_n].fe    = fe;
    step_res[step_n].ra    = ra;
    step_res[step_n].last  = 1'b0;
    step_n++;
  endtask

  task automatic add_rdsr();
    add_res(K_SPI, CMD_RDSR, 1'b1, 1'b1, 21'd1);
  endtask

  task automatic add_addr(input logic [23:0] a, input logic fe, input logic [20:0] ra);
    add_res(K_SPI, a[23:16], 1'b0, 1'b0, 21'd0);
    add_res(K_SPI, a[15:8], 1'b0, 1'b0, 21'd0);
    add_res(K_SPI, a[7:0], 1'b0, fe, ra);
  endtask

  task automatic predict_frames(input logic [2:0] m, input logic [23:0] a,
                                input logic [20:0] l, input logic [7:0] d);
    int unsigned um;
    int unsigned room;
    int unsigned u;
    step_n = 0;
    if (m <= MODE_ERASE && phase == ST_IDLE) begin
      um = sector_bytes(erase_shift) - 1;
      if (m == MODE_ERASE && ((a & um) != 0 || (l & um) != 0)) begin
        add_res(K_ALIGN, 8'h00, 1'b0, 1'b0, 21'd0);
      end else begin
        op       = m;
        cur_addr = a % DEV;
        left     = l;
        if (m != MODE_READ && l == 0) begin
          add_res(K_DONE, 8'h00, 1'b0, 1'b0, 21'd0);
        end else begin
          add_rdsr();
          phase = ST_POLL;
        end
      end
    end else if (m == MODE_STATUS && phase == ST_POLL) begin
      if (d[0]) begin
        add_rdsr();
      end else if (op == MODE_WRITE) begin
        room = PAGE - cur_addr % PAGE;
        add_res(K_SPI, CMD_WREN, 1'b1, 1'b1, 21'd0);
        add_res(K_SPI, CMD_PP, 1'b1, 1'b0, 21'd0);
        add_addr(24'(cur_addr), 1'b0, 21'd0);
        page_rem = (room < left) ? room : left;
        phase    = ST_WRITE;
      end else if (op == MODE_ERASE) begin
        u = sector_bytes(erase_shift);
        add_res(K_SPI, CMD_WREN, 1'b1, 1'b1, 21'd0);
        add_res(K_SPI, CMD_SE, 1'b1, 1'b0, 21'd0);
        add_addr(24'(cur_addr), 1'b1, 21'd0);
        cur_addr = (cur_addr + u) % DEV;
        left     = (left > u) ? left - u : 0;
        if (left == 0) begin
          add_res(K_DONE, 8'h00, 1'b0, 1'b0, 21'd0);
          phase = ST_IDLE;
        end else begin
          add_rdsr();
        end
      end else begin
        add_res(K_SPI, CMD_READ, 1'b1, 1'b0, 21'd0);
        add_addr(24'(cur_addr), 1'b1, 21'(left));
        if (left == 0) begin
          add_res(K_DONE, 8'h00, 1'b0, 1'b0, 21'd0);
          phase = ST_IDLE;
        end else begin
          phase = ST_READ;
        end
      end
    end else if (m == MODE_RBYTE && phase == ST_READ) begin
      add_res(K_HOST, ~d, 1'b0, 1'b0, 21'd0);
      if (left > 0) left--;
      if (left == 0) begin
        add_res(K_DONE, 8'h00, 1'b0, 1'b0, 21'd0);
        phase = ST_IDLE;
      end
    end else if (m == MODE_WBYTE && phase == ST_WRITE) begin
      if (page_rem > 0) page_rem--;
      if (left > 0) left--;
      cur_addr = (cur_addr + 1) % DEV;
      add_res(K_SPI, ~d, 1'b0, page_rem == 0, 21'd0);
      if (page_rem == 0) begin
        if (left == 0) begin
          add_res(K_DONE, 8'h00, 1'b0, 1'b0, 21'd0);
          phase = ST_IDLE;
        end else begin
          add_rdsr();
          phase = ST_POLL;
        end
      end
    end else begin
      add_res(K_PHASE, 8'h00, 1'b0, 1'b0, 21'd0);
    end
    step_res[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) frame_q.push_back(step_res[i]);
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 50) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase       = ST_IDLE;
      op          = MODE_READ;
      erase_shift = 5'd16;
      cur_addr    = 0;
      left        = 0;
      page_rem    = 0;
      frame_q.delete();
    end else begin
      if (cfg_we) erase_shift = cfg_wdata;
      if (in_valid && !in_stall) predict_frames(in_mode, in_address, in_length, in_data);
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          errors++;
          if (errors <= 50) begin
            $display("%0t: unexpected result, expected none, got kind %0d byte %02h",
                     $time, out_kind, out_out_byte);
          end
        end else begin
          want = frame_q.pop_front();
          checked++;
          check_field("kind", 24'(want.kind), 24'(out_kind));
          check_field("out_byte", 24'(want.obyte), 24'(out_out_byte));
          check_field("frame_start", 24'(want.fs), 24'(out_frame_start));
          check_field("frame_end", 24'(want.fe), 24'(out_frame_end));
          check_field("read_after", 24'(want.ra), 24'(out_read_after));
          check_field("last", 24'(want.last), 24'(out_last));
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// top of the spi flash command sequencer testbench: plays host and flash, drives
// requests and erase unit settings, and gives the verdict from the checker's counts
// depends on sfcs_pkg, sfcs_checker and the spi_flash_command_sequencer rtl
module tb_top import sfcs_pkg::*; ();

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 48;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [23:0] in_address;
  logic [20:0] in_length;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic        out_frame_start;
  logic        out_frame_end;
  logic [20:0] out_read_after;
  logic        out_last;

  int          chk_errors;
  int          chk_pending;
  int          chk_checked;
  int          n_items;
  int          n_reads;
  int          n_writes;
  int          n_erases;
  int          n_noise;
  int          n_settings;
  int unsigned unit_now;
  bit          gaps_ok;
  bit          in_gap_on;
  bit          out_gap_on;
  bit          hold_req;
  int          hold_left;
  int          burst_left;

  spi_flash_command_sequencer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_address(in_address), .in_length(in_length), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_out_byte(out_out_byte), .out_frame_start(out_frame_start),
    .out_frame_end(out_frame_end), .out_read_after(out_read_after), .out_last(out_last)
  );

  sfcs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_address(in_address), .in_length(in_length), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_out_byte(out_out_byte), .out_frame_start(out_frame_start),
    .out_frame_end(out_frame_end), .out_read_after(out_read_after), .out_last(out_last),
    .errors(chk_errors), .pending(chk_pending), .checked(chk_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results still outstanding", chk_pending);
    $display("Test completed with failures");
    $finish;
  end

  // result side: short random stall bursts plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (out_gap_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put_item(input logic [2:0] m, input logic [23:0] a, input logic [20:0] l,
                          input logic [7:0] d);
    if (in_gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_address <= a;
    in_length  <= l;
    in_data    <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_erase_unit(input logic [4:0] v);
    int s;
    settle(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    s = v;
    if (s < 8) s = 8;
    if (s > 20) s = 20;
    unit_now = 32'd1 << s;
    n_settings++;
  endtask

  // out-of-phase item; legal is the mode the current phase would take
  task automatic maybe_noise(input logic [2:0] legal);
    logic [2:0] m;
    if ($urandom_range(0, 11) == 0) begin
      m = 3'($urandom_range(0, 7));
      while ((legal <= MODE_ERASE) ? (m <= MODE_ERASE) : (m == legal)) begin
        m = 3'($urandom_range(0, 7));
      end
      put_item(m, 24'($urandom), 21'($urandom), 8'($urandom));
      n_noise++;
    end
  endtask

  task automatic answer_polls();
    logic [7:0] s;
    int busy;
    busy = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i <= busy; i++) begin
      maybe_noise(MODE_STATUS);
      s    = 8'($urandom);
      s[0] = (i < busy);
      put_item(MODE_STATUS, 24'($urandom), 21'($urandom), s);
    end
  endtask

  task automatic run_read(input logic [23:0] a, input int unsigned len);
    maybe_noise(MODE_READ);
    put_item(MODE_READ, a, 21'(len), 8'($urandom));
    answer_polls();
    for (int i = 0; i < len; i++) begin
      maybe_noise(MODE_RBYTE);
      put_item(MODE_RBYTE, 24'($urandom), 21'($urandom), 8'($urandom));
    end
    n_reads++;
  endtask

  task automatic run_write(input logic [23:0] a, input int unsigned len);
    int unsigned cur;
    int unsigned rest;
    int unsigned chunk;
    maybe_noise(MODE_READ);
    put_item(MODE_WRITE, a, 21'(len), 8'($urandom));
    cur  = a % DEVICE_BYTES_DEF;
    rest = len;
    while (rest > 0) begin
      answer_polls();
      chunk = PAGE_BYTES_DEF - cur % PAGE_BYTES_DEF;
      if (chunk > rest) chunk = rest;
      repeat (chunk) begin
        maybe_noise(MODE_WBYTE);
        put_item(MODE_WBYTE, 24'($urandom), 21'($urandom), 8'($urandom));
      end
      cur  = (cur + chunk) % DEVICE_BYTES_DEF;
      rest = rest - chunk;
    end
    n_writes++;
  endtask

  task automatic run_erase(input logic [23:0] a, input int unsigned len);
    int unsigned sectors;
    maybe_noise(MODE_READ);
    put_item(MODE_ERASE, a, 21'(len), 8'($urandom));
    if ((a & (unit_now - 1)) == 0 && (len & (unit_now - 1)) == 0) begin
      sectors = len / unit_now;
      repeat (sectors) answer_polls();
    end
    n_erases++;
  endtask

  task automatic random_op();
    int r;
    logic [23:0] a;
    logic [20:0] l;
    int unsigned k;
    int unsigned kmax;
    if (gaps_ok) begin
      in_gap_on  = ($urandom_range(0, 4) != 0);
      out_gap_on = ($urandom_range(0, 4) != 0);
    end
    r = $urandom_range(0, 99);
    a = 24'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        a[7:3] = 5'h1f;
      end
      1: begin
        a[19:8] = 12'hfff;
      end
      default: ;
    endcase
    if (r < 35) begin
      run_read(a, ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
    end else if (r < 70) begin
      run_write(a, ($urandom_range(0, 19) == 0) ? $urandom_range(257, 264)
                                                : $urandom_range(0, 16));
    end else if (r < 90) begin
      kmax = 21'h1fffff / unit_now;
      if (kmax > 3) kmax = 3;
      k = $urandom_range(0, kmax);
      run_erase(a & 24'(~(unit_now - 1)), k * unit_now);
    end else begin
      l = 21'($urandom);
      if ($urandom_range(0, 1)) a[0] = 1'b1;
      else l[0] = 1'b1;
      run_erase(a, l);
    end
  endtask

  initial begin
    logic [4:0] v;
    int start;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 5'd0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_READ;
    in_address <= 24'd0;
    in_length  <= 21'd0;
    in_data    <= 8'd0;
    unit_now   = 32'd1 << 16;
    gaps_ok    = 1'b1;
    in_gap_on  = 1'b1;
    out_gap_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // read past the device end with a busy poll and a request while busy
    put_item(MODE_READ, 24'hffffff, 21'd3, 8'h00);
    put_item(MODE_WRITE, 24'h000000, 21'd1, 8'h00);
    put_item(MODE_STATUS, 24'h000000, 21'h000000, 8'h01);
    put_item(MODE_STATUS, 24'hffffff, 21'h1fffff, 8'hfe);
    put_item(MODE_RBYTE, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_RBYTE, 24'h000000, 21'd0, 8'hff);
    put_item(MODE_RBYTE, 24'h000000, 21'd0, 8'ha5);
    // empty read still polls and sends its header; empty write and erase finish at once
    put_item(MODE_READ, 24'h000000, 21'd0, 8'hff);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_WRITE, 24'h123456, 21'd0, 8'h00);
    put_item(MODE_ERASE, 24'h000000, 21'd0, 8'h00);
    // misaligned erase address, then misaligned maximum length
    put_item(MODE_ERASE, 24'h000100, 21'h010000, 8'h00);
    put_item(MODE_ERASE, 24'h000000, 21'h1fffff, 8'h00);
    // program across a page boundary and the device end
    put_item(MODE_WRITE, 24'h0ffffe, 21'd3, 8'h00);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_WBYTE, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_WBYTE, 24'h000000, 21'd0, 8'hff);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h01);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_WBYTE, 24'h000000, 21'd0, 8'h5a);
    // two-sector erase wrapping the device end
    put_item(MODE_ERASE, 24'hff0000, 21'h020000, 8'h00);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_RSVD6, 24'h000000, 21'd0, 8'h00);
    put_item(MODE_RSVD7, 24'hffffff, 21'h1fffff, 8'hff);
    put_item(MODE_STATUS, 24'h000000, 21'd0, 8'h00);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: v = 5'd8;
        1: v = 5'd20;
        2: v = 5'd0;
        3: v = 5'd31;
        4: v = 5'd12;
        5: v = 5'd16;
        default: v = 5'($urandom);
      endcase
      set_erase_unit(v);
      if (p == 4) begin
        // hold the result side while requests keep coming
        hold_req  = 1'b1;
        in_gap_on = 1'b0;
        run_read(24'($urandom), 24);
      end
      if (p == 6) begin
        gaps_ok    = 1'b0;
        in_gap_on  = 1'b0;
        out_gap_on = 1'b0;
      end
      start = n_items;
      while (n_items - start < PHASE_ITEMS) random_op();
    end

    settle(20);
    $display("covered %0d requests: %0d reads, %0d writes, %0d erases, %0d out-of-phase items",
             n_items, n_reads, n_writes, n_erases, n_noise);
    $display("%0d results checked over %0d erase unit settings, with one long output hold",
             chk_checked, n_settings);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
